FILE: src/tbo_pkg.sv
// Shared types and widths for the triangle/box overlap test pipeline.
package tbo_pkg;

    localparam int CW = 32;            // coordinate width
    localparam int EW = CW - 1;        // half extent width
    localparam int DW = CW + 1;        // difference width
    localparam int NW = 2 * DW + 1;    // normal component width
    localparam int PW = NW + DW + 3;   // normal projection width
    localparam int QW = 2 * DW + 2;    // edge-axis projection width
    localparam int RW = NW + EW + 3;   // radius width
    localparam int NL = DW + 1;        // low slice of a normal component for split multiplies
    localparam int NSTG = 6;           // register stages from input beat to result

    typedef enum logic [1:0] {
        REG_HX = 2'd0,
        REG_HY = 2'd1,
        REG_HZ = 2'd2
    } t_reg_idx;

    typedef logic signed [DW-1:0] t_vec_d [3];

    // Separation of three projections against radius r (strict compares).
    function automatic logic sep3(input logic signed [PW:0] p0, input logic signed [PW:0] p1,
                                  input logic signed [PW:0] p2, input logic signed [PW:0] r);
        logic signed [PW:0] lo;
        logic signed [PW:0] hi;
        begin
            lo = p0;
            hi = p0;
            if (p1 < lo) lo = p1;
            if (p2 < lo) lo = p2;
            if (p1 > hi) hi = p1;
            if (p2 > hi) hi = p2;
            sep3 = (lo > r) || (hi < -r);
        end
    endfunction

endpackage

FILE: src/tbo_prep.sv
// Stage 1: box-relative vertices and triangle edges.
module tbo_prep (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [tbo_pkg::CW-1:0] i_p [3][3],
    input  logic signed [tbo_pkg::CW-1:0] i_c [3],
    output logic signed [tbo_pkg::DW-1:0] o_v [3][3],
    output logic signed [tbo_pkg::DW-1:0] o_f [3][3]
);
    import tbo_pkg::*;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    o_v[i][k] <= DW'(i_p[i][k]) - DW'(i_c[k]);
                    o_f[i][k] <= DW'(i_p[(i + 1) % 3][k]) - DW'(i_p[i][k]);
                end
            end
        end
    end
endmodule

FILE: src/tbo_axis.sv
// Stages 2-6: normal, edge-axis projections and per-axis separation flags.
module tbo_axis (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [tbo_pkg::DW-1:0] i_v [3][3],
    input  logic signed [tbo_pkg::DW-1:0] i_f [3][3],
    input  logic [tbo_pkg::EW-1:0]        i_ext [3],
    output logic                          o_sep
);
    import tbo_pkg::*;

    // stage 2: products
    logic signed [2*DW-1:0] r_nm [3][2];
    logic signed [2*DW-1:0] r_em [3][3][3][2]; // axis k, edge i, vertex j, term
    logic signed [DW-1:0]   r_v2 [3][3];
    logic signed [DW-1:0]   r_f2 [3][3];
    // stage 3
    logic signed [NW-1:0]   r_n [3];
    logic signed [QW-1:0]   r_ep [3][3][3];
    logic signed [RW-1:0]   r_er [3][3];
    logic signed [DW-1:0]   r_v3 [3][3];
    logic                   r_sbox;
    // stage 4: normal projections and radius, split into high and low halves
    logic signed [2*DW-1:0]       r_nph [3][3];
    logic signed [DW+NL:0]        r_npl [3][3];
    logic [EW+NW-NL-1:0]          r_nrh [3];
    logic [EW+NL-1:0]             r_nrl [3];
    logic                         r_sedge;
    logic                         r_sbox4;
    // stage 5: halves recombined
    logic signed [NW+DW-1:0] r_np [3][3];
    logic [NW+EW-1:0]        r_nr [3];
    logic                    r_sedge5;
    logic                    r_sbox5;

    function automatic logic signed [DW-1:0] eax(input int k, input int c,
                                                 input logic signed [DW-1:0] f [3]);
        logic signed [DW-1:0] z;
        begin
            z = '0;
            eax = z;
            case (k)
                0: eax = (c == 1) ? -f[2] : ((c == 2) ? f[1] : z);
                1: eax = (c == 0) ? f[2] : ((c == 2) ? -f[0] : z);
                default: eax = (c == 0) ? -f[1] : ((c == 1) ? f[0] : z);
            endcase
        end
    endfunction

    function automatic logic [DW-1:0] absd(input logic signed [DW-1:0] a);
        absd = a[DW-1] ? DW'(-a) : DW'(a);
    endfunction

    logic n_sbox;
    logic n_sedge;
    logic signed [NW-NL-1:0] nrm_hi [3];
    logic [NL-1:0]           nrm_lo [3];
    logic [NW-1:0]           nrm_mag [3];

    always_comb begin
        logic signed [PW:0] lo3 [3];
        n_sbox = 1'b0;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) lo3[j] = (PW+1)'(r_v2[j][k]);
            n_sbox = n_sbox | sep3(lo3[0], lo3[1], lo3[2], (PW+1)'({1'b0, i_ext[k]}));
        end
    end

    always_comb begin
        n_sedge = 1'b0;
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
                n_sedge = n_sedge | sep3((PW+1)'(r_ep[k][i][0]), (PW+1)'(r_ep[k][i][1]),
                                         (PW+1)'(r_ep[k][i][2]), (PW+1)'(r_er[k][i]));
    end

    // normal split so each multiply stays near 33 x 35 bits
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            nrm_hi[c]  = r_n[c][NW-1:NL];
            nrm_lo[c]  = r_n[c][NL-1:0];
            nrm_mag[c] = r_n[c][NW-1] ? NW'(-r_n[c]) : NW'(r_n[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 2
            r_nm[0][0] <= i_f[0][1] * i_f[1][2];  r_nm[0][1] <= i_f[0][2] * i_f[1][1];
            r_nm[1][0] <= i_f[0][2] * i_f[1][0];  r_nm[1][1] <= i_f[0][0] * i_f[1][2];
            r_nm[2][0] <= i_f[0][0] * i_f[1][1];  r_nm[2][1] <= i_f[0][1] * i_f[1][0];
            for (int k = 0; k < 3; k++)
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++) begin
                        r_em[k][i][j][0] <= i_v[j][(k + 1) % 3] * eax(k, (k + 1) % 3, i_f[i]);
                        r_em[k][i][j][1] <= i_v[j][(k + 2) % 3] * eax(k, (k + 2) % 3, i_f[i]);
                    end
            r_v2 <= i_v;
            r_f2 <= i_f;
            // stage 3
            for (int c = 0; c < 3; c++)
                r_n[c] <= NW'(r_nm[c][0]) - NW'(r_nm[c][1]);
            for (int k = 0; k < 3; k++)
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++)
                        r_ep[k][i][j] <= QW'(r_em[k][i][j][0]) + QW'(r_em[k][i][j][1]);
                    r_er[k][i] <= RW'({1'b0, i_ext[(k + 1) % 3]}
                                      * absd(eax(k, (k + 1) % 3, r_f2[i])))
                                + RW'({1'b0, i_ext[(k + 2) % 3]}
                                      * absd(eax(k, (k + 2) % 3, r_f2[i])));
                end
            r_v3 <= r_v2;
            r_sbox <= n_sbox;
            // stage 4
            for (int j = 0; j < 3; j++)
                for (int c = 0; c < 3; c++) begin
                    r_nph[j][c] <= r_v3[j][c] * nrm_hi[c];
                    r_npl[j][c] <= r_v3[j][c] * $signed({1'b0, nrm_lo[c]});
                end
            for (int c = 0; c < 3; c++) begin
                r_nrh[c] <= i_ext[c] * nrm_mag[c][NW-1:NL];
                r_nrl[c] <= i_ext[c] * nrm_mag[c][NL-1:0];
            end
            r_sedge <= n_sedge;
            r_sbox4 <= r_sbox;
            // stage 5
            for (int j = 0; j < 3; j++)
                for (int c = 0; c < 3; c++)
                    r_np[j][c] <= ((NW+DW)'(r_nph[j][c]) <<< NL) + (NW+DW)'(r_npl[j][c]);
            for (int c = 0; c < 3; c++)
                r_nr[c] <= ((NW+EW)'(r_nrh[c]) << NL) + (NW+EW)'(r_nrl[c]);
            r_sedge5 <= r_sedge;
            r_sbox5 <= r_sbox4;
        end
    end

    // stage 6 sums and compares on the normal axis
    logic signed [PW:0] np [3];
    logic signed [PW:0] nrad;
    always_comb begin
        for (int j = 0; j < 3; j++)
            np[j] = (PW+1)'(r_np[j][0]) + (PW+1)'(r_np[j][1]) + (PW+1)'(r_np[j][2]);
        nrad = (PW+1)'(r_nr[0]) + (PW+1)'(r_nr[1]) + (PW+1)'(r_nr[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) o_sep <= sep3(np[0], np[1], np[2], nrad) | r_sedge5 | r_sbox5;
    end
endmodule

FILE: src/triangle_box_overlap_test_unit.sv
// Top level of the triangle/box overlap test pipeline.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------
//  cfg     | i_cfg_valid/o_cfg_rdy | i_cfg_index, i_cfg_data (half extents)
//  in      | i_valid/o_ready       | nine vertex coords, three box center
//  out     | o_valid/i_ready       | o_overlaps
//
// The pipe takes one beat per cycle while the output is not stalled.
// The pipeline is six register stages (edges, products, sums, split normal
// products, normal recombine, final compare); all stages advance together
// on a shared enable. A stall at the output freezes every stage; bubbles
// are not squeezed out. Reset clears the valid bits and the half extents.
module triangle_box_overlap_test_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_rdy,
    input  logic [1:0]                    i_cfg_index,
    input  logic [tbo_pkg::EW-1:0]        i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [tbo_pkg::CW-1:0] i_vert_a_x,
    input  logic signed [tbo_pkg::CW-1:0] i_vert_a_y,
    input  logic signed [tbo_pkg::CW-1:0] i_vert_a_z,
    input  logic signed [tbo_pkg::CW-1:0] i_vert_b_x,
    input  logic signed [tbo_pkg::CW-1:0] i_vert_b_y,
    input  logic signed [tbo_pkg::CW-1:0] i_vert_b_z,
    input  logic signed [tbo_pkg::CW-1:0] i_vert_c_x,
    input  logic signed [tbo_pkg::CW-1:0] i_vert_c_y,
    input  logic signed [tbo_pkg::CW-1:0] i_vert_c_z,
    input  logic signed [tbo_pkg::CW-1:0] i_box_center_x,
    input  logic signed [tbo_pkg::CW-1:0] i_box_center_y,
    input  logic signed [tbo_pkg::CW-1:0] i_box_center_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_overlaps
);
    import tbo_pkg::*;

    logic [EW-1:0] r_ext [3];
    logic [NSTG-1:0] r_vld;
    logic en;
    logic sep;
    logic signed [CW-1:0] p [3][3];
    logic signed [CW-1:0] c [3];
    logic signed [DW-1:0] v [3][3];
    logic signed [DW-1:0] f [3][3];

    // whole pipe moves unless the last stage holds an untaken result
    assign en        = !r_vld[NSTG-1] || i_ready;
    assign o_ready   = en;
    assign o_cfg_rdy = 1'b1;
    assign o_valid   = r_vld[NSTG-1];
    assign o_overlaps = !sep;

    assign p[0] = '{i_vert_a_x, i_vert_a_y, i_vert_a_z};
    assign p[1] = '{i_vert_b_x, i_vert_b_y, i_vert_b_z};
    assign p[2] = '{i_vert_c_x, i_vert_c_y, i_vert_c_z};
    assign c    = '{i_box_center_x, i_box_center_y, i_box_center_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ext <= '{default: '0};
        end else begin
            if (en) r_vld <= {r_vld[NSTG-2:0], i_valid};
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_HX:  r_ext[0] <= i_cfg_data;
                    REG_HY:  r_ext[1] <= i_cfg_data;
                    REG_HZ:  r_ext[2] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    tbo_prep u_prep (
        .i_clk (i_clk),
        .i_en  (en),
        .i_p   (p),
        .i_c   (c),
        .o_v   (v),
        .o_f   (f)
    );

    tbo_axis u_axis (
        .i_clk (i_clk),
        .i_en  (en),
        .i_v   (v),
        .i_f   (f),
        .i_ext (r_ext),
        .o_sep (sep)
    );
endmodule

FILE: src/tbo_checker.sv
// Port-level checker for the overlap test unit, bound to the top level.
module tbo_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_overlaps
);
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready) else $error("input stalled with empty output");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_overlaps))
        else $error("result dropped under stall");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_ready |-> ##6 (o_valid || !$past(i_ready, 1)
        || !$past(i_ready, 2) || !$past(i_ready, 3) || !$past(i_ready, 4)
        || !$past(i_ready, 5)))
        else $error("result missing after latency");
endmodule

bind triangle_box_overlap_test_unit tbo_checker u_tbo_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_overlaps (o_overlaps)
);

FILE: dv/triangle_box_overlap_test_unit_tb.sv
// Self-checking testbench for the triangle/box overlap test unit.
module triangle_box_overlap_test_unit_tb;
    import tbo_pkg::*;

    localparam int WB = 160;              // wide enough for every product and sum
    localparam logic [1:0] REG_UNUSED = 2'd3;  // index past the register list

    typedef logic signed [WB-1:0] wide_t;
    typedef logic signed [CW-1:0] coord_t;

    // One triangle/box beat: a, b, c vertices (x,y,z each) then box center.
    typedef struct {
        coord_t c [12];
    } tri_box_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_rdy;
    logic [1:0] i_cfg_index;
    logic [EW-1:0] i_cfg_data;
    logic i_valid;
    logic o_ready;
    coord_t in_c [12];
    logic o_valid;
    logic i_ready;
    logic o_overlaps;

    triangle_box_overlap_test_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_rdy      (o_cfg_rdy),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_vert_a_x     (in_c[0]),
        .i_vert_a_y     (in_c[1]),
        .i_vert_a_z     (in_c[2]),
        .i_vert_b_x     (in_c[3]),
        .i_vert_b_y     (in_c[4]),
        .i_vert_b_z     (in_c[5]),
        .i_vert_c_x     (in_c[6]),
        .i_vert_c_y     (in_c[7]),
        .i_vert_c_z     (in_c[8]),
        .i_box_center_x (in_c[9]),
        .i_box_center_y (in_c[10]),
        .i_box_center_z (in_c[11]),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_overlaps     (o_overlaps)
    );

    // Local copy of the half extents, updated on each accepted write to an extent register.
    logic [EW-1:0] half_ext [3];

    tri_box_t pending_tris [$];
    logic expected_overlaps [$];
    int errors;
    bit burst_mode;     // no sender gaps while set
    bit rx_hold;        // long receiver hold-off for backpressure
    int tx_gap;
    int rx_wait;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        errors++;
    endtask

    // True when the triangle projections onto axis ax all lie strictly
    // beyond the box radius on one side.
    function automatic bit axis_separates(input wide_t rel [3][3], input wide_t ax [3]);
        wide_t proj [3];
        wide_t lo;
        wide_t hi;
        wide_t rad;
        rad = 0;
        for (int i = 0; i < 3; i++) begin
            proj[i] = rel[i][0] * ax[0] + rel[i][1] * ax[1] + rel[i][2] * ax[2];
        end
        lo = proj[0];
        hi = proj[0];
        for (int i = 1; i < 3; i++) begin
            if (proj[i] < lo) lo = proj[i];
            if (proj[i] > hi) hi = proj[i];
        end
        for (int k = 0; k < 3; k++) begin
            wide_t e;
            e = half_ext[k];
            rad += e * ((ax[k] < 0) ? -ax[k] : ax[k]);
        end
        return (lo > rad) || (hi < -rad);
    endfunction

    // Separating axis test over all thirteen candidate axes.
    function automatic logic predict_overlap(input tri_box_t t);
        wide_t pt [3][3];
        wide_t rel [3][3];
        wide_t edge_v [3][3];
        wide_t ax [3];
        bit sep;
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++) pt[i][k] = t.c[3*i+k];
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++) begin
                wide_t ctr;
                ctr = t.c[9+k];
                rel[i][k] = pt[i][k] - ctr;
                edge_v[i][k] = pt[(i+1)%3][k] - pt[i][k];
            end
        // plane normal
        ax[0] = edge_v[0][1] * edge_v[1][2] - edge_v[0][2] * edge_v[1][1];
        ax[1] = edge_v[0][2] * edge_v[1][0] - edge_v[0][0] * edge_v[1][2];
        ax[2] = edge_v[0][0] * edge_v[1][1] - edge_v[0][1] * edge_v[1][0];
        sep = axis_separates(rel, ax);
        // box faces
        for (int k = 0; k < 3; k++) begin
            ax = '{0, 0, 0};
            ax[k] = 1;
            sep |= axis_separates(rel, ax);
        end
        // box axis cross edge
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++) begin
                case (k)
                    0: ax = '{0, -edge_v[i][2], edge_v[i][1]};
                    1: ax = '{edge_v[i][2], 0, -edge_v[i][0]};
                    default: ax = '{-edge_v[i][1], edge_v[i][0], 0};
                endcase
                sep |= axis_separates(rel, ax);
            end
        return !sep;
    endfunction

    // Sender: inputs change on the falling edge only.
    bit in_beat;
    always @(negedge i_clk) begin
        logic nxt_valid;
        nxt_valid = i_valid;
        if (in_beat) begin
            nxt_valid = 1'b0;
            tx_gap = burst_mode ? 0 : $urandom_range(0, 19);
        end
        if (!nxt_valid && i_rst_n) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (pending_tris.size() > 0) begin
                tri_box_t t;
                t = pending_tris.pop_front();
                for (int j = 0; j < 12; j++) in_c[j] <= t.c[j];
                nxt_valid = 1'b1;
            end
        end
        i_valid <= nxt_valid;
    end

    // Receiver: random stall per beat, plus the long hold-off.
    bit out_beat;
    always @(negedge i_clk) begin
        int w;
        w = rx_wait;
        if (out_beat) w = burst_mode ? 0 : $urandom_range(0, 19);
        else if (w > 0) w--;
        rx_wait = w;
        i_ready <= (w == 0) && !rx_hold;
    end

    // Monitor: sample handshakes on the rising edge.
    always @(posedge i_clk) begin
        in_beat <= i_rst_n && i_valid && o_ready;
        out_beat <= i_rst_n && o_valid && i_ready;
        if (i_rst_n && i_valid && o_ready) begin
            tri_box_t t;
            for (int j = 0; j < 12; j++) t.c[j] = in_c[j];
            expected_overlaps.insert(expected_overlaps.size(), predict_overlap(t));
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_overlaps.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                logic exp_ov;
                exp_ov = expected_overlaps.pop_front();
                if (o_overlaps !== exp_ov)
                    report_mismatch($sformatf("overlaps got %b expected %b",
                                              o_overlaps, exp_ov));
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [EW-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_rdy) @(posedge i_clk);
        if (idx != REG_UNUSED) half_ext[idx] = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_box(input int hx, input int hy, input int hz);
        write_reg(REG_HX, EW'(hx));
        write_reg(REG_HY, EW'(hy));
        write_reg(REG_HZ, EW'(hz));
    endtask

    task automatic add_tri(input int ax, input int ay, input int az, input int bx,
                           input int by, input int bz, input int cx, input int cy,
                           input int cz, input int ox, input int oy, input int oz);
        tri_box_t t;
        t.c = '{ax, ay, az, bx, by, bz, cx, cy, cz, ox, oy, oz};
        pending_tris.insert(pending_tris.size(), t);
    endtask

    // Random triangle: mostly near the box so both outcomes show up,
    // the rest uniform over the whole coordinate range.
    task automatic add_random_tri();
        tri_box_t t;
        int span;
        if ($urandom_range(0, 4) == 0) begin
            for (int j = 0; j < 12; j++) t.c[j] = $urandom;
        end else begin
            span = 1 << $urandom_range(2, 30);
            for (int k = 0; k < 3; k++) begin
                t.c[9+k] = $urandom;
                for (int i = 0; i < 3; i++)
                    t.c[3*i+k] = t.c[9+k] + $signed($urandom_range(0, span)) - span / 2;
            end
        end
        pending_tris.insert(pending_tris.size(), t);
    endtask

    // Wait until every beat has been sent and answered, then let the pipe drain.
    // Checked on the rising edge, where the sender's falling-edge updates have settled.
    task automatic wait_drained();
        while (pending_tris.size() > 0 || i_valid || expected_overlaps.size() > 0)
            @(posedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    initial begin
        int one;
        errors = 0;
        burst_mode = 1'b0;
        rx_hold = 1'b0;
        tx_gap = 0;
        rx_wait = 0;
        in_beat = 1'b0;
        out_beat = 1'b0;
        half_ext = '{0, 0, 0};
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_HX;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        for (int j = 0; j < 12; j++) in_c[j] = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset extents are zero: point box at the origin.
        add_tri(0, 0, 0, 5, 0, 0, 0, 5, 0, 0, 0, 0);    // touches at a vertex
        add_tri(1, 1, 1, 5, 1, 1, 1, 5, 1, 0, 0, 0);    // just off the point
        wait_drained();

        one = 1 << 16;
        set_box(one, one, one);
        write_reg(REG_UNUSED, 31'h7fff_ffff);           // ignored write
        add_tri(0, 0, 0, 100, 0, 0, 0, 100, 0, 0, 0, 0);       // inside
        add_tri(one, 0, 0, one, 9*one, 0, one, 0, 9*one, 0, 0, 0);  // touches face
        add_tri(one+1, 0, 0, one+1, 9*one, 0, one+1, 0, 9*one, 0, 0, 0); // just off
        add_tri(-one-1, 0, 0, -9*one, 0, 0, -one-1, one, 0, 0, 0, 0); // off -x
        add_tri(50, 50, 50, 50, 50, 50, 50, 50, 50, 0, 0, 0);  // degenerate point
        add_tri(-9*one, 0, 0, 9*one, 0, 0, 0, 0, 0, 0, 0, 0); // degenerate line through
        add_tri(3*one, 0, 0, 0, 3*one, 0, 0, 0, 3*one, 0, 0, 0); // plane touches corner
        add_tri(3*one, 3*one, 0, 3*one, 0, 3*one, 0, 3*one, 3*one, 0, 0, 0);
        add_tri(2*one, -one, 0, -one, 2*one, 0, 2*one, -one, one, 0, 0, 0);
        add_tri(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        add_tri(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        add_tri(32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 0,
                32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 32'h7fffffff);
        add_tri(-1, -1, -1, -1, 0, 0, 0, -1, 0, -1, -1, -1);
        wait_drained();

        // Largest extents: everything in range overlaps unless far apart.
        set_box(31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
        add_tri(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000001, 32'h80000000,
                32'h80000000, 32'h80000000, 32'h80000001, 32'h80000000,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        add_tri(32'h7fffffff, 0, 0, 0, 32'h7fffffff, 0, 0, 0, 32'h7fffffff,
                32'h80000000, 32'h80000000, 32'h80000000);
        for (int n = 0; n < 60; n++) add_random_tri();
        wait_drained();

        // Random phases; the third one carries the receiver hold-off.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_box(0, 0, 0);
                1: set_box($urandom, $urandom, $urandom);
                default: set_box($urandom_range(0, 1 << (8 + 5*ph)),
                                 $urandom_range(0, 1 << (8 + 5*ph)),
                                 $urandom_range(0, 1 << (8 + 5*ph)));
            endcase
            burst_mode = (ph == 3);
            for (int n = 0; n < 100; n++) add_random_tri();
            if (ph == 2) begin
                // sender keeps offering while the output is blocked
                burst_mode = 1'b1;
                rx_hold = 1'b1;
                repeat (60) @(negedge i_clk);
                rx_hold = 1'b0;
                burst_mode = 1'b0;
            end
            wait_drained();
        end

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
